// ----- rtl/multi_slot_periodic_timer_defines.svh -----
// Assertion macros for the multi-slot periodic timer.
// Included by the RTL modules that carry concurrent assertions; no other dependencies.
`ifndef MULTI_SLOT_PERIODIC_TIMER_DEFINES_SVH
`define MULTI_SLOT_PERIODIC_TIMER_DEFINES_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked on every rising edge outside reset.
`define MSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, checked on every rising edge outside reset.
`define MSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define MSPT_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg)
`define MSPT_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- rtl/mspt_pkg.sv -----
// Shared types and constants for the multi-slot periodic timer.
// No dependencies; used by every module of the block.
`default_nettype none

package mspt_pkg;

  // Field widths fixed by the interface.
  localparam int OP_W       = 2;
  localparam int SLOT_W     = 3;
  localparam int PERIOD_W   = 16;
  localparam int STEP_W     = 16;
  localparam int REM_W      = 18;
  localparam int MASK_W     = 8;

  // Default table size and reset value of the tick step.
  localparam int TASK_SLOTS_DEF = 8;
  localparam logic [STEP_W-1:0] TICK_STEP_RST = 16'd1;

  // Operation codes carried by an input transaction.
  typedef enum logic [OP_W-1:0] {
    OP_TICK = 2'd0,
    OP_ADD  = 2'd1,
    OP_DEL  = 2'd2,
    OP_SET  = 2'd3
  } op_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_ADD,
    ST_DONE
  } state_t;

  // Strobes from the sequencer to the slot datapath and output stage.
  typedef struct packed {
    logic start;     // latch interval, clear the running result
    logic tick_en;   // apply the tick step to the slot under the index
    logic add_en;    // claim the slot under the index
    logic del_en;    // clear the enable of the addressed slot
    logic set_en;    // write the period of the addressed slot
    logic res_load;  // move the running result to the output register
    logic res_zero;  // load an all-zero result to the output register
  } ctl_t;

endpackage

`default_nettype wire

// ----- rtl/multi_slot_periodic_timer.sv -----
// Multi-slot periodic timer: a table of TASK_SLOTS periodic slots driven by tick,
// add, delete and set-period transactions. A tick walks every slot through one
// shared subtractor, one slot per clock; its result is then offered once the output
// register is free, and no new transaction is taken before the sequencer is idle.
// An add scans upward for the lowest free slot and stops at the first free slot
// or after the last one. Delete and set period take effect at acceptance and
// offer their result on the next cycle. The input is stalled while a transaction
// is in progress or while the output register holds a result that is itself
// stalled. tick_step resets to 1 and may be written only while the block is idle.
// Depends on mspt_pkg, mspt_ctrl and mspt_datapath.
`default_nettype none

module multi_slot_periodic_timer #(
  parameter int TASK_SLOTS = mspt_pkg::TASK_SLOTS_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // Input channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic [mspt_pkg::OP_W-1:0]       in_operation,
  input  wire logic [mspt_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic [mspt_pkg::PERIOD_W-1:0]   in_interval,
  // Result channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [mspt_pkg::MASK_W-1:0]          out_fired_mask,
  output logic                                 out_success,
  output logic [mspt_pkg::SLOT_W-1:0]          out_assigned_slot,
  // Configuration channel
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [mspt_pkg::STEP_W-1:0]     cfg_tick_step
);

  localparam int IDX_W = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;

  logic [mspt_pkg::STEP_W-1:0]  tick_step_r;
  logic                         out_valid_r;
  logic [mspt_pkg::MASK_W-1:0]  out_fired_r;
  logic                         out_success_r;
  logic [mspt_pkg::SLOT_W-1:0]  out_slot_r;
  logic                         out_busy;
  logic                         slot_busy;
  logic [IDX_W-1:0]             idx;
  mspt_pkg::ctl_t               ctl;
  logic [mspt_pkg::MASK_W-1:0]  res_fired;
  logic                         res_success;
  logic [mspt_pkg::SLOT_W-1:0]  res_slot;

  // Tick step register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_step_r <= mspt_pkg::TICK_STEP_RST;
    end else if (cfg_valid && cfg_ready) begin
      tick_step_r <= cfg_tick_step;
    end
  end

  assign out_busy = out_valid_r && out_stall;

  mspt_ctrl #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .out_busy     (out_busy),
    .slot_busy    (slot_busy),
    .in_stall     (in_stall),
    .idx          (idx),
    .ctl          (ctl)
  );

  mspt_datapath #(
    .TASK_SLOTS (TASK_SLOTS),
    .IDX_W      (IDX_W)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .ctl           (ctl),
    .idx           (idx),
    .in_slot       (in_slot),
    .in_interval   (in_interval),
    .tick_step     (tick_step_r),
    .slot_busy     (slot_busy),
    .fired_mask    (res_fired),
    .success       (res_success),
    .assigned_slot (res_slot)
  );

  // Output register: holds one result until the transaction completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.res_load || ctl.res_zero) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.res_load) begin
      out_fired_r   <= res_fired;
      out_success_r <= res_success;
      out_slot_r    <= res_slot;
    end else if (ctl.res_zero) begin
      out_fired_r   <= '0;
      out_success_r <= 1'b0;
      out_slot_r    <= '0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_fired_mask    = out_fired_r;
  assign out_success       = out_success_r;
  assign out_assigned_slot = out_slot_r;

endmodule

`default_nettype wire

// ----- rtl/mspt_ctrl.sv -----
// Sequencer of the multi-slot periodic timer: walks the slot index for ticks and adds.
// Depends on mspt_pkg and multi_slot_periodic_timer_defines.svh.
`default_nettype none
`include "multi_slot_periodic_timer_defines.svh"

module mspt_ctrl #(
  parameter int TASK_SLOTS = mspt_pkg::TASK_SLOTS_DEF,
  parameter int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic [mspt_pkg::OP_W-1:0]     in_operation,
  input  wire logic                          out_busy,
  input  wire logic                          slot_busy,
  output logic                               in_stall,
  output logic [IDX_W-1:0]                   idx,
  output mspt_pkg::ctl_t                     ctl
);

  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);

  mspt_pkg::state_t state_r, state_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             accept;
  mspt_pkg::op_t    op;

  assign op       = mspt_pkg::op_t'(in_operation);
  assign in_stall = (state_r != mspt_pkg::ST_IDLE) || out_busy;
  assign accept   = in_valid && !in_stall;
  assign idx      = idx_r;

  // State and index registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mspt_pkg::ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

  // Next state and strobes.
  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    ctl       = '0;
    case (state_r)
      mspt_pkg::ST_IDLE: begin
        if (accept) begin
          case (op)
            mspt_pkg::OP_TICK: begin
              ctl.start = 1'b1;
              idx_nxt   = '0;
              state_nxt = mspt_pkg::ST_TICK;
            end
            mspt_pkg::OP_ADD: begin
              ctl.start = 1'b1;
              idx_nxt   = '0;
              state_nxt = mspt_pkg::ST_ADD;
            end
            mspt_pkg::OP_DEL: begin
              ctl.del_en   = 1'b1;
              ctl.res_zero = 1'b1;
            end
            mspt_pkg::OP_SET: begin
              ctl.set_en   = 1'b1;
              ctl.res_zero = 1'b1;
            end
            default: ;
          endcase
        end
      end
      mspt_pkg::ST_TICK: begin
        // One slot per cycle through the shared subtractor.
        ctl.tick_en = 1'b1;
        if (idx_r == LAST_IDX) begin
          state_nxt = mspt_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      mspt_pkg::ST_ADD: begin
        // Scan upward for the lowest free slot.
        if (!slot_busy) begin
          ctl.add_en = 1'b1;
          state_nxt  = mspt_pkg::ST_DONE;
        end else if (idx_r == LAST_IDX) begin
          state_nxt = mspt_pkg::ST_DONE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      mspt_pkg::ST_DONE: begin
        if (!out_busy) begin
          ctl.res_load = 1'b1;
          state_nxt    = mspt_pkg::ST_IDLE;
        end
      end
      default: state_nxt = mspt_pkg::ST_IDLE;
    endcase
  end

  // A tick transaction always starts its walk at slot zero.
  `MSPT_ASSERT_NXT(a_tick_start, clk, rst_n, accept && (op == mspt_pkg::OP_TICK), (state_r == mspt_pkg::ST_TICK) && (idx_r == '0), "tick walk did not start at slot zero")
  // A finished result waits while the output register is still occupied.
  `MSPT_ASSERT_NXT(a_done_hold, clk, rst_n, (state_r == mspt_pkg::ST_DONE) && out_busy, state_r == mspt_pkg::ST_DONE, "result left before output register was free")

endmodule

`default_nettype wire

// ----- rtl/mspt_datapath.sv -----
// Slot table and shared subtractor of the multi-slot periodic timer.
// Depends on mspt_pkg and multi_slot_periodic_timer_defines.svh.
`default_nettype none
`include "multi_slot_periodic_timer_defines.svh"

module mspt_datapath #(
  parameter int TASK_SLOTS = mspt_pkg::TASK_SLOTS_DEF,
  parameter int IDX_W      = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire mspt_pkg::ctl_t                  ctl,
  input  wire logic [IDX_W-1:0]                idx,
  input  wire logic [mspt_pkg::SLOT_W-1:0]     in_slot,
  input  wire logic [mspt_pkg::PERIOD_W-1:0]   in_interval,
  input  wire logic [mspt_pkg::STEP_W-1:0]     tick_step,
  output logic                                 slot_busy,
  output logic [mspt_pkg::MASK_W-1:0]          fired_mask,
  output logic                                 success,
  output logic [mspt_pkg::SLOT_W-1:0]          assigned_slot
);

  // Wide enough for both the slot field and the table size.
  localparam int CMP_W = ((IDX_W > mspt_pkg::SLOT_W) ? IDX_W : mspt_pkg::SLOT_W) + 1;
  localparam int PAD_W = mspt_pkg::REM_W - mspt_pkg::PERIOD_W;

  logic                                en_r     [TASK_SLOTS];
  logic [mspt_pkg::PERIOD_W-1:0]       period_r [TASK_SLOTS];
  logic signed [mspt_pkg::REM_W-1:0]   rem_r    [TASK_SLOTS];

  logic [mspt_pkg::PERIOD_W-1:0]       interval_r;
  logic [mspt_pkg::MASK_W-1:0]         fired_r;
  logic                                success_r;
  logic [mspt_pkg::SLOT_W-1:0]         assigned_r;

  logic                                en_rd;
  logic [mspt_pkg::PERIOD_W-1:0]       period_rd;
  logic signed [mspt_pkg::REM_W-1:0]   period_ext;
  logic signed [mspt_pkg::REM_W-1:0]   rem_rd;
  logic signed [mspt_pkg::REM_W-1:0]   diff;
  logic                                fire;
  logic                                slot_ok;
  logic [IDX_W-1:0]                    wslot;
  logic [mspt_pkg::MASK_W-1:0]         fire_bit;

  // Reads at the sequencer index.
  assign en_rd      = en_r[idx];
  assign period_rd  = period_r[idx];
  assign rem_rd     = rem_r[idx];
  assign period_ext = $signed({{PAD_W{1'b0}}, period_rd});
  assign slot_busy  = en_rd;

  // Shared subtractor: the slot fires when its count reaches zero or below.
  assign diff     = rem_rd - $signed({{PAD_W{1'b0}}, tick_step});
  assign fire     = diff[mspt_pkg::REM_W-1] || (diff == '0);
  assign fire_bit = {{(mspt_pkg::MASK_W-1){1'b0}}, 1'b1} << idx;

  // Direct slot addressing for delete and set period.
  assign slot_ok = CMP_W'(in_slot) < CMP_W'(TASK_SLOTS);
  assign wslot   = IDX_W'(in_slot);

  // Enable bits, cleared at reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
        en_r[i] <= 1'b0;
      end
    end else if (ctl.add_en) begin
      en_r[idx] <= 1'b1;
    end else if (ctl.del_en && slot_ok) begin
      en_r[wslot] <= 1'b0;
    end
  end

  // Periods and counts; every enabled slot has been written by an add.
  always_ff @(posedge clk) begin
    if (ctl.add_en) begin
      period_r[idx] <= interval_r;
      rem_r[idx]    <= $signed({{PAD_W{1'b0}}, interval_r});
    end else if (ctl.set_en && slot_ok) begin
      period_r[wslot] <= in_interval;
    end else if (ctl.tick_en && en_rd) begin
      rem_r[idx] <= fire ? period_ext : diff;
    end
  end

  // Running result of the current transaction.
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      interval_r <= in_interval;
      fired_r    <= '0;
      success_r  <= 1'b0;
      assigned_r <= '0;
    end else if (ctl.tick_en && en_rd && fire) begin
      fired_r <= fired_r | fire_bit;
    end else if (ctl.add_en) begin
      success_r  <= 1'b1;
      assigned_r <= mspt_pkg::SLOT_W'(idx);
    end
  end

  assign fired_mask    = fired_r;
  assign success       = success_r;
  assign assigned_slot = assigned_r;

  // A claimed slot is enabled on the next cycle.
  `MSPT_ASSERT_NXT(a_add_enables, clk, rst_n, ctl.add_en, en_r[$past(idx)], "claimed slot not enabled")
  // A firing slot reloads its full period.
  `MSPT_ASSERT_NXT(a_fire_reload, clk, rst_n, ctl.tick_en && en_rd && fire, rem_r[$past(idx)] == $past(period_ext), "fired slot did not reload its period")

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
// Self-checking testbench for multi_slot_periodic_timer: directed and random
// tick, add, delete and set-period transactions, each result checked against a
// local slot-table predictor. Depends on mspt_pkg and the RTL of the block.

module testbench;
  import mspt_pkg::*;

  localparam int SLOTS        = TASK_SLOTS_DEF;
  localparam int DRAIN_CYCLES = SLOTS + 6;
  localparam int LONG_HOLD    = 400;
  localparam int QUIET_LIMIT  = 5000;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [MASK_W-1:0] fired_mask;
    logic              success;
    logic [SLOT_W-1:0] assigned_slot;
  } timer_result_t;

  // Clock, reset and block ports.
  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [OP_W-1:0]     in_operation = '0;
  logic [SLOT_W-1:0]   in_slot = '0;
  logic [PERIOD_W-1:0] in_interval = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [MASK_W-1:0]   out_fired_mask;
  logic                out_success;
  logic [SLOT_W-1:0]   out_assigned_slot;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [STEP_W-1:0]   cfg_tick_step = '0;

  // Predicted slot table and tick step.
  logic [STEP_W-1:0]       model_step;
  logic                    slot_on [SLOTS];
  logic [PERIOD_W-1:0]     slot_period [SLOTS];
  logic signed [REM_W-1:0] slot_count [SLOTS];
  timer_result_t           expected_results[$];

  // Idling control and statistics.
  int in_idle_pct = 0;
  int out_idle_pct = 0;
  int hold_left = 0;
  int quiet_cycles = 0;
  int mismatches = 0;
  int results_seen = 0;
  int expirations = 0;
  int adds_refused = 0;
  int step_writes = 0;
  int op_count [4] = '{0, 0, 0, 0};

  multi_slot_periodic_timer dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_slot           (in_slot),
    .in_interval       (in_interval),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_fired_mask    (out_fired_mask),
    .out_success       (out_success),
    .out_assigned_slot (out_assigned_slot),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_tick_step     (cfg_tick_step)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Applies one transaction to the predicted table and returns its result.
  function automatic timer_result_t timer_outcome(input op_t op, input logic [SLOT_W-1:0] slot,
                                                  input logic [PERIOD_W-1:0] interval);
    timer_result_t           r;
    logic signed [REM_W:0]   diff;
    r = '0;
    case (op)
      OP_TICK: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (slot_on[i]) begin
            diff = slot_count[i] - $signed({3'b000, model_step});
            // Expired: flag it and reload the full period, dropping the overshoot.
            if (diff <= 0) begin
              r.fired_mask[i] = 1'b1;
              slot_count[i] = $signed({2'b00, slot_period[i]});
            end else begin
              slot_count[i] = diff[REM_W-1:0];
            end
          end
        end
      end
      OP_ADD: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!slot_on[i]) begin
            slot_on[i] = 1'b1;
            slot_period[i] = interval;
            slot_count[i] = $signed({2'b00, interval});
            r.success = 1'b1;
            r.assigned_slot = SLOT_W'(i);
            break;
          end
        end
      end
      OP_DEL: slot_on[slot] = 1'b0;
      default: slot_period[slot] = interval;
    endcase
    return r;
  endfunction

  function automatic void note_mismatch(input string what, input timer_result_t want,
                                        input timer_result_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("MISMATCH %s: expected mask %02h success %0d slot %0d,",
               what, want.fired_mask, want.success, want.assigned_slot,
               " got mask %02h success %0d slot %0d",
               got.fired_mask, got.success, got.assigned_slot);
  endfunction

  // Sends one transaction after a random gap and predicts it once accepted.
  task automatic send_item(input op_t op, input logic [SLOT_W-1:0] slot,
                           input logic [PERIOD_W-1:0] interval);
    timer_result_t r;
    while ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_operation <= op;
    in_slot      <= slot;
    in_interval  <= interval;
    do @(posedge clk); while (in_stall);
    r = timer_outcome(op, slot, interval);
    expected_results.push_back(r);
    op_count[op]++;
    if (op == OP_ADD && !r.success)
      adds_refused++;
  endtask

  // Holds the input off until every predicted result has been taken.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Writes the tick step once the block has gone idle.
  task automatic write_tick_step(input logic [STEP_W-1:0] step);
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid     <= 1'b1;
    cfg_tick_step <= step;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    model_step = step;
    step_writes++;
  endtask

  task automatic set_idling(input int sender_pct, input int receiver_pct);
    in_idle_pct  = sender_pct;
    out_idle_pct = receiver_pct;
  endtask

  // Empty table, then every slot claimed, then an add refused on a full table.
  task automatic test_fill_table();
    send_item(OP_TICK, 3'd0, 16'd0);
    send_item(OP_ADD, 3'd7, 16'd0);
    send_item(OP_ADD, 3'd0, 16'd1);
    send_item(OP_ADD, 3'd0, 16'hFFFF);
    send_item(OP_ADD, 3'd0, 16'd2);
    send_item(OP_ADD, 3'd0, 16'd5);
    send_item(OP_ADD, 3'd0, 16'hAAAA);
    send_item(OP_ADD, 3'd0, 16'h5555);
    send_item(OP_ADD, 3'd0, 16'd3);
    send_item(OP_ADD, 3'd7, 16'hFFFF);
  endtask

  // Zero and short periods fire and reload across a few ticks.
  task automatic test_tick_reload();
    repeat (3) send_item(OP_TICK, 3'd0, 16'd0);
  endtask

  // Delete and set period on enabled and disabled slots, then reuse of a freed slot.
  task automatic test_delete_and_set();
    send_item(OP_DEL, 3'd3, 16'd0);
    send_item(OP_DEL, 3'd3, 16'd9);
    send_item(OP_SET, 3'd3, 16'd7);
    send_item(OP_SET, 3'd0, 16'hFFFF);
    send_item(OP_TICK, 3'd0, 16'd0);
    send_item(OP_ADD, 3'd0, 16'd4);
    send_item(OP_DEL, 3'd7, 16'd0);
    send_item(OP_DEL, 3'd0, 16'd0);
    send_item(OP_TICK, 3'd0, 16'd0);
  endtask

  // A zero step still fires zero-period slots; the largest step fires everything.
  task automatic test_step_extremes();
    write_tick_step(16'd0);
    send_item(OP_ADD, 3'd0, 16'd0);
    send_item(OP_TICK, 3'd0, 16'd0);
    write_tick_step(16'hFFFF);
    send_item(OP_TICK, 3'd0, 16'd0);
    send_item(OP_TICK, 3'd0, 16'd0);
    write_tick_step(16'd1);
  endtask

  // Tick-heavy random traffic with mostly short periods so slots expire often.
  task automatic run_random_items(input int count);
    op_t                 op;
    int                  pick;
    logic [PERIOD_W-1:0] interval;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 50) op = OP_TICK;
      else if (pick < 70) op = OP_ADD;
      else if (pick < 85) op = OP_DEL;
      else op = OP_SET;
      pick = $urandom_range(99);
      if (pick < 70) interval = PERIOD_W'($urandom_range(12));
      else if (pick < 90) interval = PERIOD_W'($urandom_range(255));
      else interval = PERIOD_W'($urandom);
      // Now and then the sender waits for every outstanding result.
      if ($urandom_range(79) == 0)
        drain_results();
      send_item(op, SLOT_W'($urandom_range(SLOTS - 1)), interval);
    end
  endtask

  task automatic test_random_traffic();
    write_tick_step(16'd1);
    run_random_items(250);
    write_tick_step(16'd3);
    run_random_items(250);
    set_idling(65, 25);
    write_tick_step(16'd0);
    run_random_items(170);
    write_tick_step(16'hFFFF);
    run_random_items(80);
    write_tick_step(STEP_W'($urandom_range(1, 15)));
    run_random_items(250);
    set_idling(0, 0);
    write_tick_step(STEP_W'($urandom));
    run_random_items(100);
    write_tick_step(16'd2);
    run_random_items(400);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering.
  task automatic test_backpressure();
    in_valid <= 1'b0;
    @(negedge clk);
    hold_left = LONG_HOLD;
    @(posedge clk);
    for (int n = 0; n < 24; n++)
      send_item(op_t'($urandom_range(3)), SLOT_W'($urandom_range(SLOTS - 1)),
                PERIOD_W'($urandom_range(6)));
    drain_results();
    run_random_items(20);
  endtask

  // Result channel stall: a counted hold-off first, otherwise random.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(99) < out_idle_pct);
    end
  end

  // Compare each accepted result transaction with the oldest prediction.
  always @(posedge clk) begin : check_results
    timer_result_t want;
    timer_result_t got;
    if (rst_n && out_valid && !out_stall) begin
      got = {out_fired_mask, out_success, out_assigned_slot};
      results_seen++;
      expirations += $countones(out_fired_mask);
      if (expected_results.size() == 0) begin
        note_mismatch("result with nothing expected", '0, got);
      end else begin
        want = expected_results.pop_front();
        if (got.fired_mask != want.fired_mask)
          note_mismatch("fired_mask", want, got);
        else if (got.success != want.success)
          note_mismatch("success", want, got);
        else if (got.assigned_slot != want.assigned_slot)
          note_mismatch("assigned_slot", want, got);
      end
    end
  end

  // Watchdog: ends the run after too many cycles without any transaction.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Watchdog: no transaction for %0d cycles, %0d results outstanding",
               QUIET_LIMIT, expected_results.size());
      $display("testbench NOT OK");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    model_step = TICK_STEP_RST;
    for (int i = 0; i < SLOTS; i++) begin
      slot_on[i] = 1'b0;
      slot_period[i] = '0;
      slot_count[i] = '0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_idling(25, 65);
    test_fill_table();
    test_tick_reload();
    test_delete_and_set();
    test_step_extremes();
    test_random_traffic();
    test_backpressure();

    // Let the last results come out, then wait for anything stray.
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Ran %0d tick, %0d add, %0d delete and %0d set-period transactions",
             op_count[OP_TICK], op_count[OP_ADD], op_count[OP_DEL], op_count[OP_SET],
             " over %0d step writes.", step_writes);
    $display("Checked %0d results with %0d slot expirations and %0d refused adds;",
             results_seen, expirations, adds_refused,
             " %0d mismatches.", mismatches);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
